### rtl/assert_macros.svh
// Assertion macros shared by the lowest-free ID allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge of clk, skipped while rst_n is low.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(name, prop, msg)
`define ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

### rtl/lfa_pkg.sv
// Constants, types and command/status bundles of the lowest-free ID allocator.
`default_nettype none

package lfa_pkg;

    // Bitmap geometry
    localparam int WORD_BITS = 64;
    localparam int WORDS     = 64;

    // Field widths
    localparam int ID_W     = 12;
    localparam int STATUS_W = 2;

    localparam int IDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OPEN_W    = $clog2(WORDS + 1);
    localparam int BIT_IDX_W = $clog2(WORD_BITS);
    localparam int BASE_W    = IDX_W + BIT_IDX_W;
    localparam int EXT_W     = (ID_W > BASE_W) ? ID_W : BASE_W;

    // ID / WORD_BITS by multiplication with a rounded-up reciprocal, exact for all IDs
    localparam int SHIFT   = ID_W + BIT_IDX_W;
    localparam int RECIP   = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W = ID_W + 1;
    localparam int PROD_W  = ID_W + RECIP_W;
    localparam int QUO_W   = PROD_W - SHIFT;
    localparam int CMP_W   = (QUO_W > OPEN_W) ? QUO_W : OPEN_W;

    typedef logic [ID_W-1:0]      id_t;
    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [OPEN_W-1:0]    open_t;
    typedef logic [BIT_IDX_W-1:0] bit_idx_t;
    typedef logic [BASE_W-1:0]    base_t;
    typedef logic [EXT_W-1:0]     ext_t;
    typedef logic [PROD_W-1:0]    prod_t;
    typedef logic [QUO_W-1:0]     quo_t;
    typedef logic [CMP_W-1:0]     cmp_t;
    typedef logic [WORDS-1:0]     word_flags_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GRANTED   = 2'd0,
        STATUS_NONE_FREE = 2'd1,
        STATUS_RELEASED  = 2'd2,
        STATUS_IGNORED   = 2'd3
    } status_t;

    typedef enum logic {
        ACTION_ALLOC   = 1'b0,
        ACTION_RELEASE = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        OP_FILL,
        OP_OPEN,
        OP_NONE_FREE,
        OP_RELEASE,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        logic capture;
        logic look;
        logic commit;
        op_t  op;
    } lfa_cmd_t;

    typedef struct packed {
        logic is_release;
        logic in_range;
        logic found;
        logic can_open;
    } lfa_stat_t;

endpackage

`default_nettype wire

### rtl/lfa_ctrl.sv
// Sequencer of the allocator: input/output handshakes and choice of the bitmap operation.
`default_nettype none

`include "assert_macros.svh"

module lfa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire lfa_pkg::lfa_stat_t stat,
    output lfa_pkg::lfa_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MODIFY
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    lfa_pkg::op_t   op_reg;
    lfa_pkg::op_t   op_next;
    logic           commit;
    logic           capture;

    always_comb
    begin
        commit  = (state_reg == S_MODIFY) && !(out_valid_reg && out_stall);
        capture = in_valid && ((state_reg == S_IDLE) || commit);

        if (stat.is_release)
        begin
            op_next = stat.in_range ? lfa_pkg::OP_RELEASE : lfa_pkg::OP_IGNORE;
        end
        else if (stat.found)
        begin
            op_next = lfa_pkg::OP_FILL;
        end
        else if (stat.can_open)
        begin
            op_next = lfa_pkg::OP_OPEN;
        end
        else
        begin
            op_next = lfa_pkg::OP_NONE_FREE;
        end

        case (state_reg)
            S_IDLE:
            begin
                state_next = capture ? S_LOOK : S_IDLE;
            end
            S_LOOK:
            begin
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                // Take the next word in the same cycle the result is handed over
                if (commit)
                begin
                    state_next = capture ? S_LOOK : S_IDLE;
                end
                else
                begin
                    state_next = S_MODIFY;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = commit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= lfa_pkg::OP_IGNORE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_LOOK)
            begin
                op_reg <= op_next;
            end
        end
    end

    assign in_stall    = !((state_reg == S_IDLE) || commit);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = capture;
    assign cmd.look    = (state_reg == S_LOOK);
    assign cmd.commit  = commit;
    assign cmd.op      = op_reg;

    `ASSERT_CLK(a_look_then_modify, (state_reg == S_LOOK) |=> (state_reg == S_MODIFY), "look step not followed by modify step")
    `ASSERT_CLK(a_result_from_modify, $rose(out_valid_reg) |-> $past(state_reg == S_MODIFY), "result raised outside modify step")
    `ASSERT_CLK(a_held_result_kept, (out_valid_reg && out_stall) |-> !commit, "result overwritten while stalled")

endmodule

`default_nettype wire

### rtl/lfa_dp.sv
// Datapath of the allocator: bitmap memory, full flags, opened-word count and result register.
`default_nettype none

`include "assert_macros.svh"

module lfa_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lfa_pkg::lfa_cmd_t  cmd,
    input  wire logic               action,
    input  wire lfa_pkg::id_t       release_id,
    output lfa_pkg::lfa_stat_t      stat,
    output lfa_pkg::id_t            granted_id,
    output lfa_pkg::status_t        status
);

    lfa_pkg::word_t          used_mem [lfa_pkg::WORDS];

    logic                    action_reg;
    lfa_pkg::id_t            rid_reg;
    lfa_pkg::idx_t           idx_reg;
    lfa_pkg::word_t          rdata_reg;
    lfa_pkg::id_t            granted_id_reg;
    lfa_pkg::id_t            granted_id_next;
    lfa_pkg::status_t        status_reg;
    lfa_pkg::status_t        status_next;
    lfa_pkg::word_flags_t    full_reg;
    lfa_pkg::word_flags_t    full_next;
    lfa_pkg::open_t          opened_reg;
    lfa_pkg::open_t          opened_next;

    lfa_pkg::prod_t          quo_prod;
    lfa_pkg::cmp_t           quo_cmp;
    lfa_pkg::word_flags_t    opened_mask;
    lfa_pkg::word_flags_t    avail;
    logic                    found;
    lfa_pkg::idx_t           found_idx;
    lfa_pkg::idx_t           look_idx;

    lfa_pkg::base_t          base;
    lfa_pkg::ext_t           rel_diff;
    lfa_pkg::bit_idx_t       rel_bit;
    lfa_pkg::bit_idx_t       zero_bit;
    lfa_pkg::word_t          fill_word;
    lfa_pkg::word_t          rel_word;
    logic                    mem_we;
    lfa_pkg::word_t          mem_wdata;

    function automatic lfa_pkg::idx_t first_set(input lfa_pkg::word_flags_t v);
        lfa_pkg::idx_t r;
        r = '0;
        for (int i = lfa_pkg::WORDS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = lfa_pkg::idx_t'(i);
            end
        end
        return r;
    endfunction

    function automatic lfa_pkg::bit_idx_t first_clear(input lfa_pkg::word_t v);
        lfa_pkg::bit_idx_t r;
        r = '0;
        for (int i = lfa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                r = lfa_pkg::bit_idx_t'(i);
            end
        end
        return r;
    endfunction

    // Look step: pick the word to touch
    always_comb
    begin
        quo_prod = lfa_pkg::prod_t'(rid_reg) * lfa_pkg::prod_t'(lfa_pkg::RECIP);
        quo_cmp  = lfa_pkg::cmp_t'(quo_prod[lfa_pkg::PROD_W-1:lfa_pkg::SHIFT]);

        for (int w = 0; w < lfa_pkg::WORDS; w++)
        begin
            opened_mask[w] = (lfa_pkg::open_t'(w) < opened_reg);
        end
        avail     = opened_mask & ~full_reg;
        found     = |avail;
        found_idx = first_set(avail);

        if (action_reg == lfa_pkg::ACTION_RELEASE)
        begin
            look_idx = quo_cmp[lfa_pkg::IDX_W-1:0];
        end
        else if (found)
        begin
            look_idx = found_idx;
        end
        else
        begin
            look_idx = opened_reg[lfa_pkg::IDX_W-1:0];
        end

        stat.is_release = (action_reg == lfa_pkg::ACTION_RELEASE);
        stat.in_range   = (quo_cmp < lfa_pkg::cmp_t'(opened_reg));
        stat.found      = found;
        stat.can_open   = (opened_reg < lfa_pkg::open_t'(lfa_pkg::WORDS));
    end

    // Modify step: update the word read in the look step
    always_comb
    begin
        base      = lfa_pkg::base_t'(idx_reg) * lfa_pkg::base_t'(lfa_pkg::WORD_BITS);
        rel_diff  = lfa_pkg::ext_t'(rid_reg) - lfa_pkg::ext_t'(base);
        rel_bit   = rel_diff[lfa_pkg::BIT_IDX_W-1:0];
        zero_bit  = first_clear(rdata_reg);
        fill_word = rdata_reg | (lfa_pkg::word_t'(1) << zero_bit);
        rel_word  = rdata_reg & ~(lfa_pkg::word_t'(1) << rel_bit);

        mem_we          = 1'b0;
        mem_wdata       = rdata_reg;
        full_next       = full_reg;
        opened_next     = opened_reg;
        granted_id_next = '0;
        status_next     = lfa_pkg::STATUS_IGNORED;

        case (cmd.op)
            lfa_pkg::OP_FILL:
            begin
                mem_we             = 1'b1;
                mem_wdata          = fill_word;
                full_next[idx_reg] = &fill_word;
                granted_id_next    = lfa_pkg::id_t'(base + lfa_pkg::base_t'(zero_bit));
                status_next        = lfa_pkg::STATUS_GRANTED;
            end
            lfa_pkg::OP_OPEN:
            begin
                mem_we             = 1'b1;
                mem_wdata          = lfa_pkg::word_t'(1);
                full_next[idx_reg] = 1'b0;
                opened_next        = opened_reg + lfa_pkg::open_t'(1);
                granted_id_next    = lfa_pkg::id_t'(base);
                status_next        = lfa_pkg::STATUS_GRANTED;
            end
            lfa_pkg::OP_NONE_FREE:
            begin
                status_next = lfa_pkg::STATUS_NONE_FREE;
            end
            lfa_pkg::OP_RELEASE:
            begin
                mem_we             = 1'b1;
                mem_wdata          = rel_word;
                full_next[idx_reg] = 1'b0;
                status_next        = lfa_pkg::STATUS_RELEASED;
            end
            default:
            begin
                status_next = lfa_pkg::STATUS_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= '0;
            opened_reg <= '0;
        end
        else if (cmd.commit)
        begin
            full_reg   <= full_next;
            opened_reg <= opened_next;
        end
    end

    // Words past the opened count may be read but their data is never used, so no clear
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            rid_reg    <= release_id;
        end
        if (cmd.look)
        begin
            idx_reg   <= look_idx;
            rdata_reg <= used_mem[look_idx];
        end
        if (cmd.commit)
        begin
            if (mem_we)
            begin
                used_mem[idx_reg] <= mem_wdata;
            end
            granted_id_reg <= granted_id_next;
            status_reg     <= status_next;
        end
    end

    assign granted_id = granted_id_reg;
    assign status     = status_reg;

    `ASSERT_ALWAYS(a_opened_bounded, !rst_n || (opened_reg <= lfa_pkg::open_t'(lfa_pkg::WORDS)), "opened-word count past bitmap size")
    `ASSERT_CLK(a_full_only_opened, (full_reg & ~opened_mask) == '0, "full flag set on unopened word")
    `ASSERT_CLK(a_open_only_on_open, (opened_reg != $past(opened_reg)) |-> $past(cmd.commit && (cmd.op == lfa_pkg::OP_OPEN)), "opened-word count moved without an open")

endmodule

`default_nettype wire

### rtl/lowest_free_id_allocator.sv
// Top level of the lowest-free ID allocator: sequencer plus bitmap datapath.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid / in_stall   | action, release_id
//  out     | output    | out_valid / out_stall | granted_id, status
//
// An item passes a look step that picks the word from the full flags, the opened count
// or the release ID and reads the bitmap memory, then a modify step that writes it back when
// it changes and loads the result register; the read and the write use the bitmap in separate steps.
// A new word is taken in the modify step, so a new item is accepted as the last one finishes, unless the output stalls.
// Reset clears the opened-word count and full flags at once; no clearing pass.
// A stalled result holds the modify cycle and with it the input side.
`default_nettype none

module lowest_free_id_allocator (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  action,
    input  wire logic [lfa_pkg::ID_W-1:0]     release_id,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [lfa_pkg::ID_W-1:0]   granted_id,
    output logic [lfa_pkg::STATUS_W-1:0] status
);

    lfa_pkg::lfa_cmd_t   cmd;
    lfa_pkg::lfa_stat_t  stat;
    lfa_pkg::status_t    status_w;

    lfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfa_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (action),
        .release_id (release_id),
        .stat       (stat),
        .granted_id (granted_id),
        .status     (status_w)
    );

    assign status = status_w;

endmodule

`default_nettype wire
